// ===== hw/rtl/tcgr_pkg.sv =====
// Shared types and constants for the text cell glyph renderer.
// Used by every module under hw/rtl; depends on nothing.
package tcgr_pkg;

   // defaults for the top-level parameters
   localparam int FRAME_WIDTH_DEF  = 640;
   localparam int FRAME_HEIGHT_DEF = 480;
   localparam int GRID_COLUMNS_DEF = 90;
   localparam int GRID_ROWS_DEF    = 30;
   localparam int GLYPH_COUNT_DEF  = 256;

   localparam int GLYPH_ROWS   = 8;
   localparam int GLYPH_COLS   = 8;
   localparam int MASK_BITS    = 16;
   localparam int THRESH_COUNT = GLYPH_ROWS - 1;

   // field widths
   localparam int PITCH_W = 14;
   localparam int ULINE_W = 5;
   localparam int FADDR_W = 11;
   localparam int BYTE_W  = 8;
   localparam int CROW_W  = 5;
   localparam int CCOL_W  = 7;
   localparam int CODE_W  = 8;
   localparam int PY_W    = 9;
   localparam int LX_W    = 10;
   localparam int CW_W    = 5;
   localparam int MASK_W  = 16;
   localparam int OFF_W   = 22;

   // frame coordinates and cell heights up to 1920 fit in 11 bits
   localparam int COORD_W = 11;
   // row counter covers the top 64 rows of a cell
   localparam int K_W     = 6;
   localparam int SX_W    = 3;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [PITCH_W-1:0] PITCH_RESET  = 14'd1280;
   localparam logic [ULINE_W-1:0] ULINE_RESET  = 5'd3;
   localparam logic [BYTE_W-1:0]  FORCED_BITS  = 8'hFF;

   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_RENDER = 1'b1
   } cmd_type;

   typedef enum logic {
      CSR_LINE_PITCH     = 1'b0,
      CSR_UNDERLINE_ROWS = 1'b1
   } csr_index_type;

   // one pixel row of a cell on its way into the pixel pipeline
   typedef struct packed {
      logic [COORD_W-1:0]                py;
      logic [COORD_W-1:0]                left;
      logic [CW_W-1:0]                   shown;
      logic [MASK_BITS-1:0][SX_W-1:0]    lane_sel;
      logic                              forced;
      logic                              code_ok;
      logic                              last;
   } row_type;

   typedef struct packed {
      logic               en;
      logic [FADDR_W-1:0] addr;
      logic [BYTE_W-1:0]  data;
   } font_wr_type;

endpackage

// ===== hw/rtl/tcgr_font.sv =====
// Font store: one write port, one registered read port.
// Depends on tcgr_pkg.
module tcgr_font #(
   parameter int ADDR_W = 11
) (
   input  logic                         clock,
   input  tcgr_pkg::font_wr_type        font_wr,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [tcgr_pkg::BYTE_W-1:0]  rd_data
);

   logic [tcgr_pkg::BYTE_W-1:0] store_ff [2**ADDR_W];
   logic [tcgr_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (font_wr.en) begin
         store_ff[font_wr.addr[ADDR_W-1:0]] <= font_wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tcgr_seq.sv =====
// Item intake and row sequencer: cell geometry tables, row counter, font reads.
// Depends on tcgr_pkg.
module tcgr_seq #(
   parameter int FRAME_WIDTH  = tcgr_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = tcgr_pkg::FRAME_HEIGHT_DEF,
   parameter int GRID_COLUMNS = tcgr_pkg::GRID_COLUMNS_DEF,
   parameter int GRID_ROWS    = tcgr_pkg::GRID_ROWS_DEF,
   parameter int GLYPH_COUNT  = tcgr_pkg::GLYPH_COUNT_DEF,
   parameter int MEM_ADDR_W   = 11
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_cmd,
   input  logic [tcgr_pkg::FADDR_W-1:0]     req_font_address,
   input  logic [tcgr_pkg::BYTE_W-1:0]      req_font_byte,
   input  logic [tcgr_pkg::CROW_W-1:0]      req_cell_row,
   input  logic [tcgr_pkg::CCOL_W-1:0]      req_cell_column,
   input  logic [tcgr_pkg::CODE_W-1:0]      req_glyph_code,
   input  logic                             req_underline,
   input  logic [tcgr_pkg::ULINE_W-1:0]     underline_rows,
   output logic                             issue_valid,
   input  logic                             issue_ready,
   output tcgr_pkg::row_type                issue_row,
   output tcgr_pkg::font_wr_type            font_wr,
   output logic [MEM_ADDR_W-1:0]            font_rd_addr
);

   localparam int COL_IDX_W = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
   localparam int ROW_IDX_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int COL_DEPTH = 2**COL_IDX_W;
   localparam int ROW_DEPTH = 2**ROW_IDX_W;
   localparam int GLYPH_IDX_W = MEM_ADDR_W - $clog2(tcgr_pkg::GLYPH_ROWS);
   localparam int STORE_LIMIT = GLYPH_COUNT * tcgr_pkg::GLYPH_ROWS;
   localparam int MAX_ROWS = 2**tcgr_pkg::K_W;

   // geometry tables, fixed at elaboration
   logic [tcgr_pkg::COORD_W-1:0]  col_left_tab  [COL_DEPTH];
   logic [tcgr_pkg::CW_W-1:0]     col_shown_tab [COL_DEPTH];
   logic [tcgr_pkg::MASK_BITS-1:0][tcgr_pkg::SX_W-1:0] col_lane_tab [COL_DEPTH];
   logic [tcgr_pkg::COORD_W-1:0]  row_top_tab    [ROW_DEPTH];
   logic [tcgr_pkg::COORD_W-1:0]  row_height_tab [ROW_DEPTH];
   logic [tcgr_pkg::K_W-1:0]      row_lastk_tab  [ROW_DEPTH];
   logic [tcgr_pkg::THRESH_COUNT-1:0][tcgr_pkg::COORD_W-1:0] row_thr_tab [ROW_DEPTH];

   for (genvar c = 0; c < COL_DEPTH; c++) begin : g_col
      localparam int L  = (c < GRID_COLUMNS) ? c * FRAME_WIDTH / GRID_COLUMNS : 0;
      localparam int R  = (c < GRID_COLUMNS) ? (c + 1) * FRAME_WIDTH / GRID_COLUMNS : 0;
      localparam int W  = R - L;
      localparam int WD = (W == 0) ? 1 : W;
      assign col_left_tab[c]  = tcgr_pkg::COORD_W'(L);
      assign col_shown_tab[c] =
         tcgr_pkg::CW_W'((W < tcgr_pkg::MASK_BITS) ? W : tcgr_pkg::MASK_BITS);
      for (genvar i = 0; i < tcgr_pkg::MASK_BITS; i++) begin : g_lane
         localparam int SX = ((i * tcgr_pkg::GLYPH_COLS) / WD) % tcgr_pkg::GLYPH_COLS;
         assign col_lane_tab[c][i] = tcgr_pkg::SX_W'(SX);
      end
   end

   for (genvar r = 0; r < ROW_DEPTH; r++) begin : g_row
      localparam int T  = (r < GRID_ROWS) ? r * FRAME_HEIGHT / GRID_ROWS : 0;
      localparam int B  = (r < GRID_ROWS) ? (r + 1) * FRAME_HEIGHT / GRID_ROWS : 0;
      localparam int H  = B - T;
      localparam int RC = (H < MAX_ROWS) ? H : MAX_ROWS;
      assign row_top_tab[r]    = tcgr_pkg::COORD_W'(T);
      assign row_height_tab[r] = tcgr_pkg::COORD_W'(H);
      assign row_lastk_tab[r]  = tcgr_pkg::K_W'((RC == 0) ? 0 : RC - 1);
      // glyph row g is reached once 8*k >= g*H, i.e. k >= ceil(g*H/8)
      for (genvar j = 0; j < tcgr_pkg::THRESH_COUNT; j++) begin : g_thr
         localparam int TH = ((j + 1) * H + tcgr_pkg::GLYPH_ROWS - 1) / tcgr_pkg::GLYPH_ROWS;
         assign row_thr_tab[r][j] = tcgr_pkg::COORD_W'(TH);
      end
   end

   // control state
   logic                         busy_ff, busy_in;
   logic [tcgr_pkg::K_W-1:0]     k_ff, k_in;

   // per-item payload
   logic [tcgr_pkg::COORD_W-1:0] top_ff, height_ff, left_ff;
   logic [tcgr_pkg::K_W-1:0]     lastk_ff;
   logic [tcgr_pkg::CW_W-1:0]    shown_ff;
   logic [tcgr_pkg::MASK_BITS-1:0][tcgr_pkg::SX_W-1:0] lane_ff;
   logic [tcgr_pkg::THRESH_COUNT-1:0][tcgr_pkg::COORD_W-1:0] thr_ff;
   logic [GLYPH_IDX_W-1:0]       code_ff;
   logic                         code_ok_ff, uline_ff;

   logic [COL_IDX_W-1:0]         col_idx;
   logic [ROW_IDX_W-1:0]         row_idx;
   logic                         req_fire, is_render, in_grid, cell_live;
   logic                         issue_fire, last_now;
   logic [tcgr_pkg::SX_W-1:0]    glyph_row;

   assign col_idx   = req_cell_column[COL_IDX_W-1:0];
   assign row_idx   = req_cell_row[ROW_IDX_W-1:0];
   assign is_render = tcgr_pkg::cmd_type'(req_cmd) == tcgr_pkg::CMD_RENDER;
   assign in_grid   = ({1'b0, req_cell_row} < (tcgr_pkg::CROW_W + 1)'(GRID_ROWS)) &&
                      ({1'b0, req_cell_column} < (tcgr_pkg::CCOL_W + 1)'(GRID_COLUMNS));
   assign cell_live = in_grid && (row_height_tab[row_idx] != '0);

   assign last_now   = k_ff == lastk_ff;
   assign issue_fire = busy_ff && issue_ready;
   // take the next item in the cycle that the last row goes out
   assign req_ready  = !busy_ff || (issue_ready && last_now);
   assign req_fire   = req_valid && req_ready;

   always_comb begin
      busy_in = busy_ff;
      k_in    = k_ff;
      if (issue_fire) begin
         k_in = k_ff + 1'b1;
         if (last_now) begin
            busy_in = 1'b0;
         end
      end
      if (req_fire && is_render) begin
         busy_in = cell_live;
         k_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         k_ff    <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && is_render) begin
         top_ff     <= row_top_tab[row_idx];
         height_ff  <= row_height_tab[row_idx];
         lastk_ff   <= row_lastk_tab[row_idx];
         thr_ff     <= row_thr_tab[row_idx];
         left_ff    <= col_left_tab[col_idx];
         shown_ff   <= col_shown_tab[col_idx];
         lane_ff    <= col_lane_tab[col_idx];
         code_ff    <= req_glyph_code[GLYPH_IDX_W-1:0];
         code_ok_ff <= {1'b0, req_glyph_code} < (tcgr_pkg::CODE_W + 1)'(GLYPH_COUNT);
         uline_ff   <= req_underline;
      end
   end

   // glyph row = floor(8*k / height), by counting thresholds passed
   always_comb begin
      glyph_row = '0;
      for (int j = 0; j < tcgr_pkg::THRESH_COUNT; j++) begin
         glyph_row = glyph_row +
            tcgr_pkg::SX_W'(tcgr_pkg::COORD_W'(k_ff) >= thr_ff[j]);
      end
   end

   assign font_rd_addr = {code_ff, glyph_row};

   assign issue_valid        = busy_ff;
   assign issue_row.py       = top_ff + tcgr_pkg::COORD_W'(k_ff);
   assign issue_row.left     = left_ff;
   assign issue_row.shown    = shown_ff;
   assign issue_row.lane_sel = lane_ff;
   assign issue_row.forced   = uline_ff &&
      ((12'(k_ff) + 12'(underline_rows)) >= 12'(height_ff));
   assign issue_row.code_ok  = code_ok_ff;
   assign issue_row.last     = last_now;

   assign font_wr.en   = req_fire && !is_render &&
                         ({1'b0, req_font_address} < (tcgr_pkg::FADDR_W + 1)'(STORE_LIMIT));
   assign font_wr.addr = req_font_address;
   assign font_wr.data = req_font_byte;

endmodule

// ===== hw/rtl/tcgr_pix.sv =====
// Pixel pipeline: glyph bits to scaled row mask, scan line to byte offset.
// Depends on tcgr_pkg; font data arrives from tcgr_font alongside stage one.
module tcgr_pix (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            issue_valid,
   output logic                            issue_ready,
   input  tcgr_pkg::row_type               issue_row,
   input  logic [tcgr_pkg::BYTE_W-1:0]     font_q,
   input  logic [tcgr_pkg::PITCH_W-1:0]    line_pitch,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tcgr_pkg::PY_W-1:0]       rsp_pixel_y,
   output logic [tcgr_pkg::LX_W-1:0]       rsp_left_x,
   output logic [tcgr_pkg::CW_W-1:0]       rsp_cell_width,
   output logic [tcgr_pkg::MASK_W-1:0]     rsp_row_mask,
   output logic [tcgr_pkg::OFF_W-1:0]      rsp_byte_offset,
   output logic                            rsp_last
);

   localparam int PROD_W = tcgr_pkg::COORD_W + tcgr_pkg::PITCH_W;

   logic                         s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                         s1_adv, s2_adv, s3_adv;

   tcgr_pkg::row_type            s1_ff;

   logic [tcgr_pkg::COORD_W-1:0] s2_py_ff, s2_left_ff;
   logic [tcgr_pkg::CW_W-1:0]    s2_shown_ff;
   logic [tcgr_pkg::MASK_W-1:0]  s2_mask_ff, mask_in;
   logic [tcgr_pkg::OFF_W-1:0]   s2_prod_ff;
   logic                         s2_last_ff;
   logic [PROD_W-1:0]            prod_full;
   logic [tcgr_pkg::BYTE_W-1:0]  bits;

   logic [tcgr_pkg::PY_W-1:0]    s3_py_ff;
   logic [tcgr_pkg::LX_W-1:0]    s3_left_ff;
   logic [tcgr_pkg::CW_W-1:0]    s3_shown_ff;
   logic [tcgr_pkg::MASK_W-1:0]  s3_mask_ff;
   logic [tcgr_pkg::OFF_W-1:0]   s3_off_ff, off_in;
   logic                         s3_last_ff;

   // each stage advances when empty or when the next one takes its row
   assign s3_adv      = !s3_valid_ff || rsp_ready;
   assign s2_adv      = !s2_valid_ff || s3_adv;
   assign s1_adv      = !s1_valid_ff || s2_adv;
   assign issue_ready = s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            s1_valid_ff <= issue_valid;
         end
         if (s2_adv) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_adv) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // stage two: select glyph bits, spread them over the lanes
   always_comb begin
      if (s1_ff.forced) begin
         bits = tcgr_pkg::FORCED_BITS;
      end else if (s1_ff.code_ok) begin
         bits = font_q;
      end else begin
         bits = '0;
      end
      for (int i = 0; i < tcgr_pkg::MASK_BITS; i++) begin
         mask_in[i] = (tcgr_pkg::CW_W'(i) < s1_ff.shown) &&
            bits[tcgr_pkg::SX_W'(tcgr_pkg::GLYPH_COLS - 1) - s1_ff.lane_sel[i]];
      end
   end

   assign prod_full = s1_ff.py * line_pitch;

   // stage three: add the column term to the line start
   assign off_in = s2_prod_ff +
      tcgr_pkg::OFF_W'({s2_left_ff, 1'b0});

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_ff <= issue_row;
      end
      if (s2_adv) begin
         s2_py_ff    <= s1_ff.py;
         s2_left_ff  <= s1_ff.left;
         s2_shown_ff <= s1_ff.shown;
         s2_mask_ff  <= mask_in;
         s2_prod_ff  <= prod_full[tcgr_pkg::OFF_W-1:0];
         s2_last_ff  <= s1_ff.last;
      end
      if (s3_adv) begin
         s3_py_ff    <= s2_py_ff[tcgr_pkg::PY_W-1:0];
         s3_left_ff  <= s2_left_ff[tcgr_pkg::LX_W-1:0];
         s3_shown_ff <= s2_shown_ff;
         s3_mask_ff  <= s2_mask_ff;
         s3_off_ff   <= off_in;
         s3_last_ff  <= s2_last_ff;
      end
   end

   assign rsp_valid       = s3_valid_ff;
   assign rsp_pixel_y     = s3_py_ff;
   assign rsp_left_x      = s3_left_ff;
   assign rsp_cell_width  = s3_shown_ff;
   assign rsp_row_mask    = s3_mask_ff;
   assign rsp_byte_offset = s3_off_ff;
   assign rsp_last        = s3_last_ff;

endmodule

// ===== hw/rtl/text_cell_glyph_renderer.sv =====
// Top level of the text cell glyph renderer: control registers and wiring.
// Depends on tcgr_pkg, tcgr_seq, tcgr_font and tcgr_pix.

// A load item (cmd 0) writes one byte of the 8x8 font store and produces no
// result; addresses at or above GLYPH_COUNT*8 are dropped. A render item
// (cmd 1) produces one result per pixel row of its cell, top row first, with
// last set on the final one, the rows being the cell height capped at 64 (16
// at the default 480-line frame). The row sequencer issues one row per cycle
// while the pixel pipeline accepts it, so a render item holds the input until
// its final row is issued. Cells outside the grid or of zero height produce
// nothing. The pixel pipeline behind the sequencer has three register stages
// and holds every row while the result side stalls. Cell bounds and glyph
// scaling are fixed by the frame and grid parameters. Registers sit at byte 0
// (line_pitch, reset 1280) and byte 4 (underline_rows, reset 3); write them
// only while no render is in flight. Font bytes read before they are loaded
// are undefined.
module text_cell_glyph_renderer #(
   parameter int FRAME_WIDTH  = tcgr_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = tcgr_pkg::FRAME_HEIGHT_DEF,
   parameter int GRID_COLUMNS = tcgr_pkg::GRID_COLUMNS_DEF,
   parameter int GRID_ROWS    = tcgr_pkg::GRID_ROWS_DEF,
   parameter int GLYPH_COUNT  = tcgr_pkg::GLYPH_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [tcgr_pkg::FADDR_W-1:0]        req_font_address,
   input  logic [tcgr_pkg::BYTE_W-1:0]         req_font_byte,
   input  logic [tcgr_pkg::CROW_W-1:0]         req_cell_row,
   input  logic [tcgr_pkg::CCOL_W-1:0]         req_cell_column,
   input  logic [tcgr_pkg::CODE_W-1:0]         req_glyph_code,
   input  logic                                req_underline,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tcgr_pkg::PY_W-1:0]           rsp_pixel_y,
   output logic [tcgr_pkg::LX_W-1:0]           rsp_left_x,
   output logic [tcgr_pkg::CW_W-1:0]           rsp_cell_width,
   output logic [tcgr_pkg::MASK_W-1:0]         rsp_row_mask,
   output logic [tcgr_pkg::OFF_W-1:0]          rsp_byte_offset,
   output logic                                rsp_last,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tcgr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tcgr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tcgr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int GLYPH_IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
   localparam int MEM_ADDR_W  = GLYPH_IDX_W + $clog2(tcgr_pkg::GLYPH_ROWS);

   logic [tcgr_pkg::PITCH_W-1:0] line_pitch_ff, line_pitch_in;
   logic [tcgr_pkg::ULINE_W-1:0] underline_rows_ff, underline_rows_in;
   tcgr_pkg::csr_index_type      csr_index;
   logic                         csr_write;

   logic                         issue_valid, issue_ready;
   tcgr_pkg::row_type            issue_row;
   tcgr_pkg::font_wr_type        font_wr;
   logic [MEM_ADDR_W-1:0]        font_rd_addr;
   logic [tcgr_pkg::BYTE_W-1:0]  font_q;

   // control registers
   assign csr_pready = 1'b1;
   assign csr_index  = tcgr_pkg::csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      line_pitch_in     = line_pitch_ff;
      underline_rows_in = underline_rows_ff;
      if (csr_write) begin
         unique case (csr_index)
            tcgr_pkg::CSR_LINE_PITCH:
               line_pitch_in = csr_pwdata[tcgr_pkg::PITCH_W-1:0];
            tcgr_pkg::CSR_UNDERLINE_ROWS:
               underline_rows_in = csr_pwdata[tcgr_pkg::ULINE_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         tcgr_pkg::CSR_LINE_PITCH:
            csr_prdata = tcgr_pkg::CSR_DATA_W'(line_pitch_ff);
         tcgr_pkg::CSR_UNDERLINE_ROWS:
            csr_prdata = tcgr_pkg::CSR_DATA_W'(underline_rows_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_pitch_ff     <= tcgr_pkg::PITCH_RESET;
         underline_rows_ff <= tcgr_pkg::ULINE_RESET;
      end else begin
         line_pitch_ff     <= line_pitch_in;
         underline_rows_ff <= underline_rows_in;
      end
   end

   tcgr_seq #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT),
      .GRID_COLUMNS (GRID_COLUMNS),
      .GRID_ROWS    (GRID_ROWS),
      .GLYPH_COUNT  (GLYPH_COUNT),
      .MEM_ADDR_W   (MEM_ADDR_W)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_font_address (req_font_address),
      .req_font_byte    (req_font_byte),
      .req_cell_row     (req_cell_row),
      .req_cell_column  (req_cell_column),
      .req_glyph_code   (req_glyph_code),
      .req_underline    (req_underline),
      .underline_rows   (underline_rows_ff),
      .issue_valid      (issue_valid),
      .issue_ready      (issue_ready),
      .issue_row        (issue_row),
      .font_wr          (font_wr),
      .font_rd_addr     (font_rd_addr)
   );

   // the read is taken in the cycle the row enters stage one
   tcgr_font #(
      .ADDR_W (MEM_ADDR_W)
   ) u_font (
      .clock   (clock),
      .font_wr (font_wr),
      .rd_en   (issue_ready),
      .rd_addr (font_rd_addr),
      .rd_data (font_q)
   );

   tcgr_pix u_pix (
      .clock           (clock),
      .reset           (reset),
      .issue_valid     (issue_valid),
      .issue_ready     (issue_ready),
      .issue_row       (issue_row),
      .font_q          (font_q),
      .line_pitch      (line_pitch_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_left_x      (rsp_left_x),
      .rsp_cell_width  (rsp_cell_width),
      .rsp_row_mask    (rsp_row_mask),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_last        (rsp_last)
   );

`ifndef SYNTH
   // a new item only overlaps the final row of the previous cell
   a_intake_after_last_row: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && issue_valid |-> issue_ready && issue_row.last)
      else $error("item taken while cell rows still pending");

   // a cell outside the grid starts no rows
   a_off_grid_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (tcgr_pkg::cmd_type'(req_cmd) == tcgr_pkg::CMD_RENDER) &&
      (({1'b0, req_cell_row} >= (tcgr_pkg::CROW_W + 1)'(GRID_ROWS)) ||
       ({1'b0, req_cell_column} >= (tcgr_pkg::CCOL_W + 1)'(GRID_COLUMNS)))
      |=> !issue_valid)
      else $error("off-grid cell produced rows");

   // mask bits beyond the valid width stay clear
   a_mask_within_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cell_width <= tcgr_pkg::CW_W'(tcgr_pkg::MASK_BITS)) &&
                    ((rsp_row_mask >> rsp_cell_width) == '0))
      else $error("row mask wider than cell width");
`endif

endmodule

// ===== test/text_cell_glyph_renderer_tb.sv =====
// Self-checking testbench for text_cell_glyph_renderer: font loads, cell renders and
// register writes, with per-row results checked against an in-bench predictor.
// Depends on tcgr_pkg and the text_cell_glyph_renderer RTL.
`timescale 1ns / 1ps

module text_cell_glyph_renderer_tb;
   import tcgr_pkg::*;

   localparam int FONT_DEPTH   = 2048;
   localparam int MAX_ROWS     = 64;
   localparam int PHASE_ITEMS  = 20;
   localparam int PHASE_COUNT  = 8;
   localparam int SETTLE_CYCLES = 12;
   localparam int QUIET_LIMIT  = 2000;
   localparam int PRINT_LIMIT  = 100;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_t;

   typedef struct packed {
      logic [PY_W-1:0]   py;
      logic [LX_W-1:0]   lx;
      logic [CW_W-1:0]   width;
      logic [MASK_W-1:0] mask;
      logic [OFF_W-1:0]  off;
      logic              last;
   } pixel_row_t;

   typedef struct packed {
      cmd_type            cmd;
      logic [FADDR_W-1:0] addr;
      logic [BYTE_W-1:0]  fbyte;
      logic [CROW_W-1:0]  crow;
      logic [CCOL_W-1:0]  ccol;
      logic [CODE_W-1:0]  code;
      logic               uline;
      logic               has_literal;
      pixel_row_t         literal_row;
   } cell_item_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_ready;
   cell_item_t cur_item = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [PY_W-1:0]       rsp_pixel_y;
   logic [LX_W-1:0]       rsp_left_x;
   logic [CW_W-1:0]       rsp_cell_width;
   logic [MASK_W-1:0]     rsp_row_mask;
   logic [OFF_W-1:0]      rsp_byte_offset;
   logic                  rsp_last;

   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   idle_mode_t idle_mode = IDLE_NONE;
   int         mismatch_count = 0;
   int         quiet_cycles = 0;

   // predictor state
   logic [BYTE_W-1:0]  glyph_mirror [0:FONT_DEPTH-1];
   logic [PITCH_W-1:0] pitch_mirror = PITCH_RESET;
   logic [ULINE_W-1:0] uline_mirror = ULINE_RESET;
   pixel_row_t         expected_rows [$];

   // stimulus side bookkeeping: which glyphs are fully loaded
   bit  font_written [0:FONT_DEPTH-1];
   bit  glyph_ready [0:GLYPH_COUNT_DEF-1];
   int  ready_codes [$];
   cell_item_t directed_items [$];

   text_cell_glyph_renderer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (cur_item.cmd),
      .req_font_address (cur_item.addr),
      .req_font_byte    (cur_item.fbyte),
      .req_cell_row     (cur_item.crow),
      .req_cell_column  (cur_item.ccol),
      .req_glyph_code   (cur_item.code),
      .req_underline    (cur_item.uline),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_left_x       (rsp_left_x),
      .rsp_cell_width   (rsp_cell_width),
      .rsp_row_mask     (rsp_row_mask),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t ERROR %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Work out every pixel row that one render transfer produces.
   task automatic predict_cell_rows(input cell_item_t it);
      int left, right, top, bottom, height, width, shown, rows;
      int py, idx, sx;
      longint off;
      logic [BYTE_W-1:0] bits;
      pixel_row_t row;
      if (it.crow >= GRID_ROWS_DEF || it.ccol >= GRID_COLUMNS_DEF)
         return;
      left   = int'(it.ccol) * FRAME_WIDTH_DEF / GRID_COLUMNS_DEF;
      right  = (int'(it.ccol) + 1) * FRAME_WIDTH_DEF / GRID_COLUMNS_DEF;
      top    = int'(it.crow) * FRAME_HEIGHT_DEF / GRID_ROWS_DEF;
      bottom = (int'(it.crow) + 1) * FRAME_HEIGHT_DEF / GRID_ROWS_DEF;
      height = bottom - top;
      width  = right - left;
      if (height == 0)
         return;
      shown = (width < MASK_BITS) ? width : MASK_BITS;
      rows  = (height < MAX_ROWS) ? height : MAX_ROWS;
      for (int k = 0; k < rows; k++) begin
         py   = top + k;
         bits = '0;
         if (int'(it.code) < GLYPH_COUNT_DEF) begin
            idx  = int'(it.code) * GLYPH_ROWS + k * GLYPH_ROWS / height;
            bits = glyph_mirror[idx % FONT_DEPTH];
         end
         if (it.uline && py + int'(uline_mirror) >= bottom)
            bits = FORCED_BITS;
         row = '0;
         for (int i = 0; i < shown; i++) begin
            sx = i * GLYPH_COLS / width;
            if (bits[GLYPH_COLS-1-sx])
               row.mask[i] = 1'b1;
         end
         off       = longint'(py) * longint'(pitch_mirror) + longint'(left) * 2;
         row.py    = PY_W'(py);
         row.lx    = LX_W'(left);
         row.width = CW_W'(shown);
         row.off   = off[OFF_W-1:0];
         row.last  = (k + 1 == rows);
         expected_rows.push_back(row);
      end
   endtask

   task automatic accept_item(input cell_item_t it);
      int first;
      if (it.cmd == CMD_LOAD) begin
         if (int'(it.addr) < GLYPH_COUNT_DEF * GLYPH_ROWS)
            glyph_mirror[it.addr] = it.fbyte;
      end else begin
         first = expected_rows.size();
         predict_cell_rows(it);
         // the typed-in first row replaces the predicted one
         if (it.has_literal && expected_rows.size() > first)
            expected_rows[first] = it.literal_row;
      end
   endtask

   task automatic check_pixel_row();
      pixel_row_t want;
      if (expected_rows.size() == 0) begin
         report_mismatch("result with nothing expected, pixel_y", rsp_pixel_y, 0);
         return;
      end
      want = expected_rows.pop_front();
      if (rsp_pixel_y != want.py)
         report_mismatch("pixel_y", rsp_pixel_y, want.py);
      if (rsp_left_x != want.lx)
         report_mismatch("left_x", rsp_left_x, want.lx);
      if (rsp_cell_width != want.width)
         report_mismatch("cell_width", rsp_cell_width, want.width);
      if (rsp_row_mask != want.mask)
         report_mismatch("row_mask", rsp_row_mask, want.mask);
      if (rsp_byte_offset != want.off)
         report_mismatch("byte_offset", rsp_byte_offset, want.off);
      if (rsp_last != want.last)
         report_mismatch("last", rsp_last, want.last);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            accept_item(cur_item);
         if (rsp_valid && rsp_ready)
            check_pixel_row();
      end
   end

   // Watchdog: end the run when nothing transfers for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_psel && csr_penable && csr_pready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (idle_mode == IDLE_RECEIVER)
         rsp_ready <= ($urandom_range(0, 99) >= 69);
      else if (idle_mode == IDLE_BOTH)
         rsp_ready <= ($urandom_range(0, 99) >= 37);
      else
         rsp_ready <= 1'b1;
   end

   function automatic bit sender_idles();
      if (idle_mode == IDLE_SENDER)
         return $urandom_range(0, 99) < 69;
      if (idle_mode == IDLE_BOTH)
         return $urandom_range(0, 99) < 37;
      return 1'b0;
   endfunction

   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return BYTE_W'($urandom);
      endcase
   endfunction

   function automatic cell_item_t load_item(input int addr, input int fbyte);
      cell_item_t it;
      it       = '0;
      it.cmd   = CMD_LOAD;
      it.addr  = FADDR_W'(addr);
      it.fbyte = BYTE_W'(fbyte);
      it.crow  = CROW_W'($urandom);
      it.ccol  = CCOL_W'($urandom);
      it.code  = CODE_W'($urandom);
      it.uline = $urandom_range(0, 1);
      return it;
   endfunction

   function automatic cell_item_t render_item(input int crow, input int ccol, input int code,
                                              input bit uline);
      cell_item_t it;
      it       = '0;
      it.cmd   = CMD_RENDER;
      it.addr  = FADDR_W'($urandom);
      it.fbyte = BYTE_W'($urandom);
      it.crow  = CROW_W'(crow);
      it.ccol  = CCOL_W'(ccol);
      it.code  = CODE_W'(code);
      it.uline = uline;
      return it;
   endfunction

   function automatic cell_item_t with_first_row(input cell_item_t it, input int py,
                                                 input int lx, input int width,
                                                 input int mask, input int off);
      it.has_literal       = 1'b1;
      it.literal_row.py    = PY_W'(py);
      it.literal_row.lx    = LX_W'(lx);
      it.literal_row.width = CW_W'(width);
      it.literal_row.mask  = MASK_W'(mask);
      it.literal_row.off   = OFF_W'(off);
      it.literal_row.last  = 1'b0;
      return it;
   endfunction

   // Present one item and hold it until the transfer.
   task automatic send_item(input cell_item_t it);
      int code;
      bit complete;
      if (it.cmd == CMD_LOAD) begin
         font_written[it.addr] = 1'b1;
         code     = int'(it.addr) / GLYPH_ROWS;
         complete = 1'b1;
         for (int r = 0; r < GLYPH_ROWS; r++)
            if (!font_written[code * GLYPH_ROWS + r])
               complete = 1'b0;
         if (complete && !glyph_ready[code]) begin
            glyph_ready[code] = 1'b1;
            ready_codes.push_back(code);
         end
      end
      @(negedge clock);
      while (sender_idles()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      cur_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold the sender until every expected row is back, then let the pipe empty.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rows.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_transfer(input bit wr, input csr_index_type idx,
                               input logic [CSR_DATA_W-1:0] wdata,
                               output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_ADDR_W'(int'(idx) * 4);
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic program_reg(input csr_index_type idx, input int value);
      logic [CSR_DATA_W-1:0] rd;
      csr_transfer(1'b1, idx, CSR_DATA_W'(value), rd);
      if (idx == CSR_LINE_PITCH)
         pitch_mirror = PITCH_W'(value);
      else
         uline_mirror = ULINE_W'(value);
      csr_transfer(1'b0, idx, '0, rd);
      if (idx == CSR_LINE_PITCH && rd[PITCH_W-1:0] != pitch_mirror)
         report_mismatch("line_pitch readback", rd, pitch_mirror);
      if (idx == CSR_UNDERLINE_ROWS && rd[ULINE_W-1:0] != uline_mirror)
         report_mismatch("underline_rows readback", rd, uline_mirror);
   endtask

   task automatic run_random(input int quota);
      int sent;
      int roll;
      int code;
      sent = 0;
      while (sent < quota) begin
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            // full glyph: all eight rows, so it can be rendered afterwards
            code = $urandom_range(0, GLYPH_COUNT_DEF - 1);
            for (int r = 0; r < GLYPH_ROWS; r++)
               send_item(load_item(code * GLYPH_ROWS + r, pick_byte()));
            sent += GLYPH_ROWS;
         end else if (roll < 25) begin
            send_item(load_item($urandom_range(0, FONT_DEPTH - 1), pick_byte()));
            sent++;
         end else if (roll < 33) begin
            // off the grid: ignored by the block
            if ($urandom_range(0, 1))
               send_item(render_item($urandom_range(GRID_ROWS_DEF, 31), $urandom_range(0, 127),
                                     $urandom_range(0, 255), $urandom_range(0, 1)));
            else
               send_item(render_item($urandom_range(0, 31),
                                     $urandom_range(GRID_COLUMNS_DEF, 127),
                                     $urandom_range(0, 255), $urandom_range(0, 1)));
            sent++;
         end else begin
            code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
            send_item(render_item($urandom_range(0, GRID_ROWS_DEF - 1),
                                  $urandom_range(0, GRID_COLUMNS_DEF - 1),
                                  code, $urandom_range(0, 1)));
            sent++;
         end
      end
   endtask

   initial begin
      int pitch_value;
      int uline_value;
      bit [BYTE_W-1:0] x_rows [0:GLYPH_ROWS-1];
      x_rows = '{8'h81, 8'h42, 8'h24, 8'h18, 8'h18, 8'h24, 8'h42, 8'h81};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: two glyphs, then corners, off-grid cells and extremes
      for (int r = 0; r < GLYPH_ROWS; r++)
         directed_items.push_back(load_item(8'h41 * GLYPH_ROWS + r, x_rows[r]));
      for (int r = 0; r < GLYPH_ROWS; r++)
         directed_items.push_back(load_item(8'hFF * GLYPH_ROWS + r, 8'hFF));
      directed_items.push_back(with_first_row(render_item(0, 0, 8'hFF, 1'b0),
                                              0, 0, 7, 16'h007F, 0));
      directed_items.push_back(with_first_row(render_item(29, 89, 8'h41, 1'b1),
                                              464, 632, 8, 16'h0081, 595184));
      directed_items.push_back(render_item(30, 0, 8'h41, 1'b0));
      directed_items.push_back(render_item(0, 90, 8'h41, 1'b1));
      directed_items.push_back(render_item(31, 127, 8'hFF, 1'b1));
      directed_items.push_back(with_first_row(render_item(15, 45, 8'h41, 1'b0),
                                              240, 320, 7, 16'h0001, 307840));
      directed_items.push_back(load_item(FONT_DEPTH - 1, 8'h00));
      directed_items.push_back(load_item(0, 8'hA5));
      directed_items.push_back(render_item(0, 1, 8'hFF, 1'b1));
      directed_items.push_back(render_item(16, 64, 8'h41, 1'b1));

      foreach (directed_items[n])
         send_item(directed_items[n]);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         wait_for_drain();
         case (ph)
            0: begin pitch_value = 2;    uline_value = 0;  end
            1: begin pitch_value = 8192; uline_value = 16; end
            3: begin pitch_value = 1280; uline_value = 3;  end
            4: begin pitch_value = 8192; uline_value = 0;  end
            5: begin pitch_value = 2;    uline_value = 16; end
            default: begin
               pitch_value = $urandom_range(2, 8192);
               uline_value = $urandom_range(0, 16);
            end
         endcase
         program_reg(CSR_LINE_PITCH, pitch_value);
         program_reg(CSR_UNDERLINE_ROWS, uline_value);
         idle_mode = idle_mode_t'(ph % 4);
         run_random(PHASE_ITEMS);
      end

      wait_for_drain();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/tcgr_pkg.sv
hw/rtl/tcgr_font.sv
hw/rtl/tcgr_seq.sv
hw/rtl/tcgr_pix.sv
hw/rtl/text_cell_glyph_renderer.sv
test/text_cell_glyph_renderer_tb.sv
